FILE: sv/bfamc_pkg.sv
// shared constants and controller/datapath interface types for the assignment search
package bfamc_pkg;

   localparam int DEF_MAX_WORKERS = 8;
   localparam int COST_W          = 16;
   localparam int SUM_W           = 19;
   localparam int CSR_W           = 4;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;         // store the accepted word
      logic search_init;  // mark the first permutation
      logic sum_init;     // clear the row walk and the accumulator
      logic sum_run;      // walk the rows of the current permutation
      logic cmp;          // fold the total into the best total
      logic desc;         // latch the rightmost descent
      logic swap;         // swap pivot with its rightmost larger entry
      logic rev;          // reverse the suffix after the pivot
      logic finish;       // back to the identity and an empty matrix
   } bfamc_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic sum_done;
      logic has_next;
   } bfamc_status_type;

endpackage

FILE: sv/bfamc_ctrl.sv
// controller state machine: load, then sum / compare / next-permutation loop
module bfamc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        req_last,
   input  bfamc_pkg::bfamc_status_type status,
   output bfamc_pkg::bfamc_cmd_type    cmd,
   output logic                        busy,
   output logic                        rsp_valid
);
   import bfamc_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SUM  = 7'b0000010,
      S_CMP  = 7'b0000100,
      S_DESC = 7'b0001000,
      S_SWAP = 7'b0010000,
      S_REV  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.search_init = 1'b1;
                  cmd.sum_init    = 1'b1;
                  state_in        = S_SUM;
               end
            end
         end
         S_SUM: begin
            cmd.sum_run = 1'b1;
            if (status.sum_done) state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_DESC;
         end
         S_DESC: begin
            cmd.desc = 1'b1;
            state_in = status.has_next ? S_SWAP : S_DONE;
         end
         S_SWAP: begin
            cmd.swap = 1'b1;
            state_in = S_REV;
         end
         S_REV: begin
            cmd.rev      = 1'b1;
            cmd.sum_init = 1'b1;
            state_in     = S_SUM;
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   // result strobe lasts one cycle and returns to idle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && state_ff == S_IDLE)
      else $error("result strobe not single or no return to idle");

   // swap only right after a successful descent search
   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWAP |-> $past(state_ff) == S_DESC && $past(status.has_next))
      else $error("swap without descent");

   // row walk is not cut short
   a_sum_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SUM && !status.sum_done |=> state_ff == S_SUM)
      else $error("row walk left early");

endmodule

FILE: sv/bfamc_datapath.sv
// datapath: cost memory, permutation registers, row accumulator and best total
module bfamc_datapath #(
   parameter int MAX_WORKERS = bfamc_pkg::DEF_MAX_WORKERS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bfamc_pkg::bfamc_cmd_type           cmd,
   output bfamc_pkg::bfamc_status_type        status,
   input  logic                               csr_write_en,
   input  logic [bfamc_pkg::CSR_W-1:0]        csr_write_data,
   input  logic signed [bfamc_pkg::COST_W-1:0] cost,
   output logic signed [bfamc_pkg::SUM_W-1:0]  min_cost
);
   import bfamc_pkg::*;

   localparam int PW    = $clog2(MAX_WORKERS);
   localparam int NW    = $clog2(MAX_WORKERS + 1);
   localparam int AW    = $clog2(MAX_WORKERS * MAX_WORKERS);
   localparam int LW    = $clog2(MAX_WORKERS * MAX_WORKERS + 1);
   localparam int Depth = MAX_WORKERS * MAX_WORKERS;

   logic signed [COST_W-1:0] cost_mem_ff [Depth];
   logic signed [COST_W-1:0] rdata_ff;

   logic [NW-1:0]    side_ff, side_in;
   logic [LW-1:0]    load_idx_ff, load_idx_in;
   logic [PW-1:0]    perm_ff [MAX_WORKERS];
   logic [PW-1:0]    perm_in [MAX_WORKERS];
   logic [NW-1:0]    w_ff, w_in;
   logic [AW-1:0]    base_ff, base_in;
   logic             pend_ff;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] best_ff, best_in;
   logic             first_ff, first_in;
   logic [NW-1:0]    desc_i_ff, desc_i_in;

   logic [LW-1:0]    nsq;
   logic             load_ok;
   logic             issue;
   logic [AW-1:0]    rd_addr;
   logic             desc_found;
   logic [NW-1:0]    desc_i;
   logic [PW-1:0]    pivot_idx;
   logic [PW-1:0]    pivot;
   logic [PW-1:0]    swap_j;

   // matrix size and load gate
   assign nsq     = LW'(side_ff) * LW'(side_ff);
   assign load_ok = (load_idx_ff < nsq);

   // row walk: one cost word read per cycle
   assign issue   = cmd.sum_run && (w_ff < side_ff);
   assign rd_addr = base_ff + AW'(perm_ff[w_ff[PW-1:0]]);

   // cost memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) cost_mem_ff[load_idx_ff[AW-1:0]] <= cost;
      if (issue) rdata_ff <= cost_mem_ff[rd_addr];
   end

   // rightmost descent
   always_comb begin
      desc_found = 1'b0;
      desc_i     = '0;
      for (int k = 1; k < MAX_WORKERS; k++) begin
         if ((NW'(k) < side_ff) && (perm_ff[k-1] < perm_ff[k])) begin
            desc_found = 1'b1;
            desc_i     = NW'(k);
         end
      end
   end

   // pivot and its rightmost larger entry
   assign pivot_idx = PW'(desc_i_ff - 1'b1);
   assign pivot     = perm_ff[pivot_idx];
   always_comb begin
      swap_j = '0;
      for (int k = 0; k < MAX_WORKERS; k++) begin
         if ((NW'(k) < side_ff) && (perm_ff[k] > pivot)) swap_j = PW'(k);
      end
   end

   // permutation update
   always_comb begin
      int src;
      src = 0;
      for (int k = 0; k < MAX_WORKERS; k++) perm_in[k] = perm_ff[k];
      if (cmd.finish) begin
         for (int k = 0; k < MAX_WORKERS; k++) perm_in[k] = PW'(k);
      end else if (cmd.swap) begin
         perm_in[pivot_idx] = perm_ff[swap_j];
         perm_in[swap_j]    = pivot;
      end else if (cmd.rev) begin
         for (int k = 0; k < MAX_WORKERS; k++) begin
            src = int'(side_ff) - 1 + int'(desc_i_ff) - k;
            if ((NW'(k) >= desc_i_ff) && (NW'(k) < side_ff)) perm_in[k] = perm_ff[PW'(src)];
         end
      end
   end

   // counters, accumulator and best total
   always_comb begin
      side_in     = side_ff;
      load_idx_in = load_idx_ff;
      w_in        = w_ff;
      base_in     = base_ff;
      acc_in      = acc_ff;
      best_in     = best_ff;
      first_in    = first_ff;
      desc_i_in   = desc_i_ff;
      if (csr_write_en) begin
         if (csr_write_data == '0) begin
            side_in = NW'(1);
         end else if (int'(csr_write_data) > MAX_WORKERS) begin
            side_in = NW'(MAX_WORKERS);
         end else begin
            side_in = NW'(csr_write_data);
         end
      end
      if (cmd.load && load_ok) load_idx_in = load_idx_ff + 1'b1;
      if (cmd.finish) load_idx_in = '0;
      if (cmd.search_init) first_in = 1'b1;
      if (cmd.sum_init) begin
         w_in    = '0;
         base_in = '0;
         acc_in  = '0;
      end
      if (issue) begin
         w_in    = w_ff + 1'b1;
         base_in = base_ff + AW'(side_ff);
      end
      if (pend_ff) acc_in = acc_ff + {{(SUM_W-COST_W){rdata_ff[COST_W-1]}}, rdata_ff};
      if (cmd.cmp) begin
         if (first_ff || ($signed(acc_ff) < $signed(best_ff))) best_in = acc_ff;
         first_in = 1'b0;
      end
      if (cmd.desc) desc_i_in = desc_i;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= NW'(1);
         load_idx_ff <= '0;
         w_ff        <= '0;
         base_ff     <= '0;
         pend_ff     <= 1'b0;
         acc_ff      <= '0;
         best_ff     <= '0;
         first_ff    <= 1'b0;
         desc_i_ff   <= '0;
         for (int k = 0; k < MAX_WORKERS; k++) perm_ff[k] <= PW'(k);
      end else begin
         side_ff     <= side_in;
         load_idx_ff <= load_idx_in;
         w_ff        <= w_in;
         base_ff     <= base_in;
         pend_ff     <= issue;
         acc_ff      <= acc_in;
         best_ff     <= best_in;
         first_ff    <= first_in;
         desc_i_ff   <= desc_i_in;
         for (int k = 0; k < MAX_WORKERS; k++) perm_ff[k] <= perm_in[k];
      end
   end

   assign status.sum_done = (w_ff == side_ff) && !pend_ff;
   assign status.has_next = desc_found;
   assign min_cost        = $signed(best_ff);

   // row walk never runs past the side
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_run |-> w_ff <= side_ff)
      else $error("row walk past matrix side");

   // first total of a search always becomes the best
   a_first_best: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp && first_ff |=> best_ff == $past(acc_ff))
      else $error("first total not taken as best");

   // end of search leaves an empty matrix and the identity
   a_finish_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> load_idx_ff == '0 && perm_ff[0] == '0)
      else $error("search end did not clear load state");

endmodule

FILE: sv/brute_force_assignment_min_cost.sv
// top level of the exhaustive assignment search: controller plus datapath
// The cost matrix loads one word per cycle in row-major order (worker row, task column)
// while busy is low; words beyond N*N are dropped. The word with req_last high starts
// the search and busy stays high until the single result. Every permutation is summed
// by walking its N rows through the one read port of the cost memory, one row per cycle;
// then the total is compared with the best and the next permutation is formed. The
// result appears on rsp_min_cost for exactly one cycle with rsp_valid; the receiver
// cannot stall it and must take it then. Write csr_write_data (the side N, 0 taken as 1,
// above MAX_WORKERS taken as MAX_WORKERS) only while idle.
module brute_force_assignment_min_cost #(
   parameter int MAX_WORKERS = bfamc_pkg::DEF_MAX_WORKERS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [bfamc_pkg::COST_W-1:0] req_cost,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic signed [bfamc_pkg::SUM_W-1:0]  rsp_min_cost,
   input  logic                                csr_write_en,
   input  logic [bfamc_pkg::CSR_W-1:0]         csr_write_data
);
   import bfamc_pkg::*;

   bfamc_cmd_type    cmd;
   bfamc_status_type status;

   // sequencer
   bfamc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // storage and arithmetic
   bfamc_datapath #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cost           (req_cost),
      .min_cost       (rsp_min_cost)
   );

endmodule

FILE: test/tb_brute_force_assignment_min_cost.sv
// self-checking testbench for the exhaustive assignment search, min cost per cost matrix
module tb_brute_force_assignment_min_cost;
   timeunit 1ns;
   timeprecision 1ps;

   import bfamc_pkg::*;

   localparam int MAX_W       = DEF_MAX_WORKERS;
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int RANDOM_WORDS = 1550;

   typedef struct {
      logic signed [COST_W-1:0] cost;
      logic                     last;
   } matrix_word_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [COST_W-1:0] req_cost = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic signed [SUM_W-1:0]  rsp_min_cost;
   logic                     csr_write_en = 1'b0;
   logic [CSR_W-1:0]         csr_write_data = '0;

   // words waiting for the driver and min costs waiting for the block
   matrix_word_type         pending_words[$];
   logic signed [SUM_W-1:0] min_cost_expected[$];
   matrix_word_type         next_word;
   logic                    word_taken = 1'b0;
   int unsigned             gap_pct = 0;
   int unsigned             words_queued = 0;
   int unsigned             words_accepted = 0;
   int unsigned             error_count = 0;
   int unsigned             cycle_count = 0;

   // predictor copy of the block state
   logic signed [COST_W-1:0] cost_mem[MAX_W*MAX_W];
   int                       load_count = 0;
   logic [CSR_W-1:0]         side_setting = CSR_W'(1);

   // stimulus side view of which entries hold a loaded value
   bit                       entry_loaded[MAX_W*MAX_W];
   int                       gen_fill = 0;
   int                       gen_side = 1;

   brute_force_assignment_min_cost DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cost       (req_cost),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_min_cost   (rsp_min_cost),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // matrix side actually used for a register value
   function automatic int matrix_side(input logic [CSR_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_W) return MAX_W;
      return int'(raw);
   endfunction

   // smallest total over every task order, walked in lexicographic order
   function automatic logic signed [SUM_W-1:0] cheapest_assignment(input int n);
      int order[MAX_W];
      int best, acc, i, j, tmp;
      bit more;
      bit first;
      for (i = 0; i < n; i++) order[i] = i;
      best = 0;
      first = 1'b1;
      do begin
         acc = 0;
         for (i = 0; i < n; i++) acc += int'(cost_mem[i*n + order[i]]);
         if (first || acc < best) best = acc;
         first = 1'b0;
         // step to the next order: pivot, swap, flip the tail
         i = n - 1;
         while (i > 0 && order[i-1] > order[i]) i--;
         more = (i > 0);
         if (more) begin
            j = n - 1;
            while (order[j] < order[i-1]) j--;
            tmp = order[i-1];
            order[i-1] = order[j];
            order[j] = tmp;
            j = n - 1;
            while (i < j) begin
               tmp = order[i];
               order[i] = order[j];
               order[j] = tmp;
               i++;
               j--;
            end
         end
      end while (more);
      return best[SUM_W-1:0];
   endfunction

   // store an accepted word and predict the min cost on the last one
   task automatic absorb_word(input logic signed [COST_W-1:0] c, input logic l);
      int n;
      n = matrix_side(side_setting);
      if (load_count < n*n) begin
         cost_mem[load_count] = c;
         load_count++;
      end
      if (l) begin
         min_cost_expected.push_back(cheapest_assignment(n));
         load_count = 0;
      end
   endtask

   task automatic note_error(input string msg);
      if (error_count < 10) $display("%s", msg);
      error_count++;
   endtask

   // acceptance flag for the driver, seen at the next falling edge
   always @(posedge clock) begin
      word_taken <= start && !busy && !reset;
   end

   // driver: one word per accepted start, random gaps between words
   always @(negedge clock) begin
      if (start && !word_taken) begin
         // word still held off by busy
      end else if (pending_words.size() > 0 && $urandom_range(99) >= gap_pct) begin
         next_word = pending_words.pop_front();
         start    <= 1'b1;
         req_cost <= next_word.cost;
         req_last <= next_word.last;
      end else begin
         start    <= 1'b0;
         req_cost <= COST_W'($urandom);
         req_last <= 1'($urandom);
      end
   end

   // monitor: check results, then track register writes and accepted words
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (min_cost_expected.size() == 0) begin
               note_error($sformatf("unexpected min_cost %0d", rsp_min_cost));
            end else if (rsp_min_cost !== min_cost_expected[0]) begin
               note_error($sformatf("min_cost mismatch: expected %0d, got %0d",
                                    min_cost_expected[0], rsp_min_cost));
               void'(min_cost_expected.pop_front());
            end else begin
               void'(min_cost_expected.pop_front());
            end
         end
         if (csr_write_en) side_setting = csr_write_data;
         if (start && !busy) begin
            absorb_word(req_cost, req_last);
            words_accepted++;
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // cost values weighted toward the extremes and small numbers
   function automatic logic signed [COST_W-1:0] pick_cost();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 16'sh7FFF;
      if (r < 20) return 16'sh8000;
      if (r < 50) return COST_W'($urandom_range(200) - 100);
      return COST_W'($urandom);
   endfunction

   task automatic queue_word(input logic signed [COST_W-1:0] c, input logic l);
      matrix_word_type w;
      w.cost = c;
      w.last = l;
      pending_words.push_back(w);
      words_queued++;
      if (gen_fill < gen_side*gen_side) begin
         entry_loaded[gen_fill] = 1'b1;
         gen_fill++;
      end
      if (l) gen_fill = 0;
   endtask

   // queue count words ending in last, grown so no unloaded entry is searched
   task automatic queue_matrix(input int count);
      int k;
      if (count < 1) count = 1;
      for (k = gen_side*gen_side - 1; k >= gen_fill + count; k--) begin
         if (!entry_loaded[k]) begin
            count = k - gen_fill + 1;
            break;
         end
      end
      for (k = 0; k < count; k++) queue_word(pick_cost(), k == count - 1);
   endtask

   // wait until every queued word is taken and every min cost has come
   task automatic wait_drained();
      while (words_accepted != words_queued || min_cost_expected.size() != 0)
         @(negedge clock);
   endtask

   // register write while the block is idle
   task automatic write_side(input logic [CSR_W-1:0] raw);
      wait_drained();
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= raw;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      csr_write_data <= CSR_W'($urandom);
      gen_side = matrix_side(raw);
   endtask

   // stimulus
   initial begin : stimulus
      int unsigned gap_table[4];
      int          phase, target, n, remaining, mats, m, r, k;
      logic [CSR_W-1:0] raw;
      gap_table = '{0, 56, 0, 23};
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // side register at zero acts as one: single word extremes
      write_side(0);
      queue_word(16'sh7FFF, 1'b1);
      queue_word(16'sh8000, 1'b1);
      // 2x2 all minimum and all maximum
      write_side(2);
      for (k = 0; k < 4; k++) queue_word(16'sh8000, k == 3);
      for (k = 0; k < 4; k++) queue_word(16'sh7FFF, k == 3);
      // extra words past the matrix are dropped
      for (k = 0; k < 6; k++) queue_word(pick_cost(), k == 5);
      // short matrix reuses entries from the previous one
      queue_word(pick_cost(), 1'b0);
      queue_word(pick_cost(), 1'b1);
      // side changed partway through a load
      write_side(2);
      queue_word(pick_cost(), 1'b0);
      queue_word(pick_cost(), 1'b0);
      write_side(3);
      for (k = 0; k < 7; k++) queue_word(pick_cost(), k == 6);

      // largest side once, register value beyond the maximum
      target = words_queued + RANDOM_WORDS;
      write_side(15);
      queue_matrix(64);

      phase = 0;
      while (words_queued < target) begin
         r = $urandom_range(99);
         if (r < 15) n = 1;
         else if (r < 40) n = 2;
         else if (r < 65) n = 3;
         else if (r < 85) n = 4;
         else if (r < 95) n = 5;
         else if (r < 99) n = 6;
         else n = 7;
         raw = (n == 1 && $urandom_range(1) == 1) ? 4'd0 : CSR_W'(n);
         write_side(raw);
         gap_pct = gap_table[phase % 4];
         phase++;
         mats = (n >= 6) ? 1 : $urandom_range(1, 4);
         for (m = 0; m < mats; m++) begin
            remaining = gen_side*gen_side - gen_fill;
            if (remaining < 1) remaining = 1;
            r = $urandom_range(99);
            if (r < 70) begin
               queue_matrix(remaining);
            end else if (r < 80) begin
               queue_matrix(remaining + $urandom_range(1, 4));
            end else if (r < 88) begin
               queue_matrix($urandom_range(1, remaining));
            end else begin
               // partial load without last, finished later or after a side change
               for (k = $urandom_range(1, 3); k > 0; k--) queue_word(pick_cost(), 1'b0);
            end
            if ($urandom_range(9) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (50) @(negedge clock);
      if (min_cost_expected.size() != 0)
         note_error($sformatf("%0d min_cost words never came", min_cost_expected.size()));
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
